/* rtl/core/tccl_pkg.sv */
// Shared types and constants for the thermal charge current limiter.
// No dependencies; imported by tccl_core and the top level.
package tccl_pkg;

  localparam int unsigned LEVELS = 4;
  localparam logic [1:0] LEVEL_TOP = 2'(LEVELS - 1);

  localparam logic [9:0]  KELVIN_OFFSET = 10'd273;
  localparam logic [9:0]  KELVIN_HIGH   = 10'd393;   // 120 C
  localparam logic [16:0] UNLIMITED_MA  = 17'd99999;

  localparam logic        REQ_POLL   = 1'b0;
  localparam logic        REQ_CHARGE = 1'b1;

  localparam logic [2:0] REG_PERSIST       = 3'd0;
  localparam logic [2:0] REG_TRIGGER_ONE   = 3'd1;
  localparam logic [2:0] REG_TRIGGER_TWO   = 3'd2;
  localparam logic [2:0] REG_TRIGGER_THREE = 3'd3;
  localparam logic [2:0] REG_RELEASE_ONE   = 3'd4;
  localparam logic [2:0] REG_RELEASE_TWO   = 3'd5;
  localparam logic [2:0] REG_RELEASE_THREE = 3'd6;
  localparam logic [2:0] REG_LIMIT_TABLE   = 3'd7;

  localparam logic [3:0]  PERSIST_RESET     = 4'd5;
  localparam logic [6:0]  TRIGGER_ONE_RESET = 7'd49;
  localparam logic [6:0]  TRIGGER_TWO_RESET = 7'd57;
  localparam logic [6:0]  TRIGGER_THR_RESET = 7'd60;
  localparam logic [6:0]  RELEASE_ONE_RESET = 7'd47;
  localparam logic [6:0]  RELEASE_TWO_RESET = 7'd55;
  localparam logic [6:0]  RELEASE_THR_RESET = 7'd58;
  localparam logic [47:0] LIMIT_TABLE_RESET = {16'd1000, 16'd1800, 16'd2300};

  typedef struct packed {
    logic [3:0]  persist_count;
    logic [6:0]  trigger_one;
    logic [6:0]  trigger_two;
    logic [6:0]  trigger_three;
    logic [6:0]  release_one;
    logic [6:0]  release_two;
    logic [6:0]  release_three;
    logic [47:0] limit_table;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] charge_ma;
    logic        system_on;
    logic        ext_power;
    logic [9:0]  sensor_kelvin;
  } item_t;

  typedef struct packed {
    logic [15:0] granted_current;
    logic [16:0] limit_ma;
    logic [1:0]  limit_level;
  } result_t;

endpackage

/* rtl/core/tccl_core.sv */
// Level tracking, persistence counters and current clamp for one request.
// Depends on tccl_pkg; state advances when step is high for a poll tick.
module tccl_core (
  input  logic             clk,
  input  logic             rst,
  input  tccl_pkg::cfg_t   cfg,
  input  tccl_pkg::item_t  item,
  input  logic             step,
  output tccl_pkg::result_t res
);
  import tccl_pkg::*;

  logic [1:0]  level, level_next;
  logic [3:0]  rise_count, rise_count_next;
  logic [3:0]  fall_count, fall_count_next;
  logic [16:0] active_limit, active_limit_next;

  logic        temp_ok;
  logic [6:0]  temp_c;
  logic [6:0]  trig_thr, rel_thr;
  logic [1:0]  lvl_mid;
  logic [3:0]  rc_inc, fc_inc;
  logic [15:0] granted;

  always_comb begin
    temp_ok  = (item.sensor_kelvin > KELVIN_OFFSET) && (item.sensor_kelvin < KELVIN_HIGH);
    temp_c   = 7'(item.sensor_kelvin - KELVIN_OFFSET);
    level_next      = level;
    rise_count_next = rise_count;
    fall_count_next = fall_count;
    lvl_mid  = level;
    rc_inc   = 4'(rise_count + 4'd1);
    fc_inc   = 4'd0;
    trig_thr = cfg.trigger_one;
    rel_thr  = cfg.release_one;

    unique case (level)
      2'd0:    trig_thr = cfg.trigger_one;
      2'd1:    trig_thr = cfg.trigger_two;
      default: trig_thr = cfg.trigger_three;
    endcase

    if (!(item.ext_power && item.system_on && temp_ok)) begin
      level_next = 2'd0;
    end else begin
      if (level < LEVEL_TOP) begin
        if (temp_c >= trig_thr) begin
          rise_count_next = rc_inc;
          if (rc_inc >= cfg.persist_count) begin
            lvl_mid = 2'(level + 2'd1);
            rise_count_next = 4'd0;
            fall_count_next = 4'd0;
          end
        end else begin
          rise_count_next = 4'd0;
        end
      end
      level_next = lvl_mid;
      unique case (lvl_mid)
        2'd1:    rel_thr = cfg.release_one;
        2'd2:    rel_thr = cfg.release_two;
        default: rel_thr = cfg.release_three;
      endcase
      fc_inc = 4'(fall_count_next + 4'd1);
      if (lvl_mid != 2'd0) begin
        if (temp_c < rel_thr) begin
          fall_count_next = fc_inc;
          if (fc_inc >= cfg.persist_count) begin
            level_next = 2'(lvl_mid - 2'd1);
            rise_count_next = 4'd0;
            fall_count_next = 4'd0;
          end
        end else begin
          fall_count_next = 4'd0;
        end
      end
    end

    unique case (level_next)
      2'd0:    active_limit_next = UNLIMITED_MA;
      2'd1:    active_limit_next = {1'b0, cfg.limit_table[15:0]};
      2'd2:    active_limit_next = {1'b0, cfg.limit_table[31:16]};
      default: active_limit_next = {1'b0, cfg.limit_table[47:32]};
    endcase

    granted = ({1'b0, item.charge_ma} < active_limit) ?
              item.charge_ma : active_limit[15:0];

    if (item.req_type == REQ_POLL) begin
      res.limit_level     = level_next;
      res.limit_ma        = active_limit_next;
      res.granted_current = 16'd0;
    end else begin
      res.limit_level     = level;
      res.limit_ma        = active_limit;
      res.granted_current = granted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= 2'd0;
      rise_count   <= 4'd0;
      fall_count   <= 4'd0;
      active_limit <= 17'd0;
    end else if (step && item.req_type == REQ_POLL) begin
      level        <= level_next;
      rise_count   <= rise_count_next;
      fall_count   <= fall_count_next;
      active_limit <= active_limit_next;
    end
  end

endmodule

/* rtl/core/thermal_charge_current_limiter_top.sv */
// Top level of the thermal charge current limiter: stream handshake,
// configuration registers, input and result registers. Depends on tccl_pkg, tccl_core.
//
// Usage:
//   Requests enter on the s_ stream; s_tuser is the kind (0 poll tick,
//   1 charge request). Every request yields exactly one result on the m_
//   stream, in order: level, active current limit and granted current.
//   A request is registered in the input register on acceptance and its
//   result is then registered in the result register, which drives m_tvalid.
//   One request is taken every cycle unless the receiver stalls; the input
//   register and the result register form a two-stage pipeline that advances
//   whenever the result register is empty or being taken.
//   When the receiver stalls, both stages hold and s_tready drops once the
//   input register is full; nothing is lost or repeated.
//   Reset clears the level, counters and active limit (a charge request
//   before any poll is granted 0 mA), empties both stages and restores the
//   register defaults. Configuration writes (cfg_we, cfg_index, cfg_data)
//   take effect at the clock edge and belong to idle periods.
module thermal_charge_current_limiter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sensor_kelvin[9:0], ext_power, system_on, charge_ma[15:0]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // limit_level[1:0], limit_ma[16:0], granted_current[15:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import tccl_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t res, out_res;
  logic    out_valid;
  logic    advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.persist_count <= PERSIST_RESET;
      cfg.trigger_one   <= TRIGGER_ONE_RESET;
      cfg.trigger_two   <= TRIGGER_TWO_RESET;
      cfg.trigger_three <= TRIGGER_THR_RESET;
      cfg.release_one   <= RELEASE_ONE_RESET;
      cfg.release_two   <= RELEASE_TWO_RESET;
      cfg.release_three <= RELEASE_THR_RESET;
      cfg.limit_table   <= LIMIT_TABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERSIST:       cfg.persist_count <= cfg_data[3:0];
        REG_TRIGGER_ONE:   cfg.trigger_one   <= cfg_data[6:0];
        REG_TRIGGER_TWO:   cfg.trigger_two   <= cfg_data[6:0];
        REG_TRIGGER_THREE: cfg.trigger_three <= cfg_data[6:0];
        REG_RELEASE_ONE:   cfg.release_one   <= cfg_data[6:0];
        REG_RELEASE_TWO:   cfg.release_two   <= cfg_data[6:0];
        REG_RELEASE_THREE: cfg.release_three <= cfg_data[6:0];
        REG_LIMIT_TABLE:   cfg.limit_table   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type      <= s_tuser;
      in_item.sensor_kelvin <= s_tdata[9:0];
      in_item.ext_power     <= s_tdata[10];
      in_item.system_on     <= s_tdata[11];
      in_item.charge_ma     <= s_tdata[27:12];
    end
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  tccl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .step (advance && in_valid),
    .res  (res)
  );

endmodule

/* tb/sv/tb_thermal_charge_current_limiter_top.sv */
`timescale 1ns / 100ps
// Testbench for thermal_charge_current_limiter_top: a queue-fed stream driver, a result
// monitor and a behavioural model of the level, counters and current limit.
// Depends on tccl_pkg and the RTL top level.
module tb_thermal_charge_current_limiter_top;
  import tccl_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam int TEMP_MAX_C = 120;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    item_t req;
    bit    settle;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // model copy of the registers and state
  logic [3:0]  mdl_persist;
  logic [6:0]  mdl_trigger [3];
  logic [6:0]  mdl_release [3];
  logic [47:0] mdl_table;
  logic [1:0]  mdl_level;
  logic [3:0]  mdl_rise;
  logic [3:0]  mdl_fall;
  logic [16:0] mdl_limit;

  pending_t request_q[$];
  result_t  level_expect_q[$];
  pending_t next_req;
  item_t    bus_req;
  result_t  got;
  result_t  want;
  int       n_in = 0;
  int       n_out = 0;
  int       fail_count = 0;
  int       quiet_cycles = 0;
  int       src_wait = 0;
  int       snk_wait = 0;
  bit       src_idle = 1'b1;
  bit       snk_idle = 1'b1;
  bit       settle_next = 1'b0;

  thermal_charge_current_limiter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic void apply_reg(input logic [2:0] idx, input logic [47:0] val);
    case (idx)
      REG_PERSIST:       mdl_persist = val[3:0];
      REG_TRIGGER_ONE:   mdl_trigger[0] = val[6:0];
      REG_TRIGGER_TWO:   mdl_trigger[1] = val[6:0];
      REG_TRIGGER_THREE: mdl_trigger[2] = val[6:0];
      REG_RELEASE_ONE:   mdl_release[0] = val[6:0];
      REG_RELEASE_TWO:   mdl_release[1] = val[6:0];
      REG_RELEASE_THREE: mdl_release[2] = val[6:0];
      REG_LIMIT_TABLE:   mdl_table = val;
      default: ;
    endcase
  endfunction

  function automatic result_t thermal_step(input item_t it);
    result_t r;
    int      temp_c;
    int      lv;
    r = '0;
    if (it.req_type == REQ_POLL) begin
      temp_c = int'(it.sensor_kelvin) - int'(KELVIN_OFFSET);
      if (!(it.ext_power && it.system_on) || temp_c <= 0 || temp_c >= TEMP_MAX_C) begin
        mdl_level = '0;
      end else begin
        if (mdl_level < LEVEL_TOP) begin
          if (temp_c >= int'(mdl_trigger[mdl_level])) begin
            mdl_rise = mdl_rise + 4'd1;
            if (mdl_rise >= mdl_persist) begin
              mdl_level = mdl_level + 2'd1;
              mdl_rise = '0;
              mdl_fall = '0;
            end
          end else begin
            mdl_rise = '0;
          end
        end
        if (mdl_level != 2'd0) begin
          lv = int'(mdl_level) - 1;
          if (temp_c < int'(mdl_release[lv])) begin
            mdl_fall = mdl_fall + 4'd1;
            if (mdl_fall >= mdl_persist) begin
              mdl_level = mdl_level - 2'd1;
              mdl_rise = '0;
              mdl_fall = '0;
            end
          end else begin
            mdl_fall = '0;
          end
        end
      end
      lv = int'(mdl_level);
      if (lv == 0) begin
        mdl_limit = UNLIMITED_MA;
      end else begin
        mdl_limit = {1'b0, mdl_table[16 * (lv - 1) +: 16]};
      end
    end else begin
      r.granted_current = (it.charge_ma < mdl_limit) ? it.charge_ma : mdl_limit[15:0];
    end
    r.limit_level = mdl_level;
    r.limit_ma = mdl_limit;
    return r;
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void add_item(input item_t it);
    pending_t p;
    p.req = it;
    p.settle = settle_next || ($urandom_range(0, 199) == 0);
    settle_next = 1'b0;
    request_q.push_back(p);
  endfunction

  function automatic void add_poll(input int kelvin, input bit ext_on, input bit sys_on);
    item_t it;
    it.req_type = REQ_POLL;
    it.sensor_kelvin = 10'(kelvin);
    it.ext_power = ext_on;
    it.system_on = sys_on;
    it.charge_ma = 16'($urandom);
    add_item(it);
  endfunction

  function automatic void add_charge(input logic [15:0] cur);
    item_t it;
    it.req_type = REQ_CHARGE;
    it.sensor_kelvin = 10'($urandom);
    it.ext_power = 1'($urandom);
    it.system_on = 1'($urandom);
    it.charge_ma = cur;
    add_item(it);
  endfunction

  function automatic logic [15:0] pick_current();
    int k;
    k = $urandom_range(0, 2);
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return mdl_table[16 * k +: 16] + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly runs of valid polls near a threshold, with charge requests and noise between
  function automatic void fill_phase(input int n);
    int  target;
    int  run_len;
    int  k;
    int  pick;
    bit  settled;
    settled = 1'b0;
    while (request_q.size() < n) begin
      if (!settled && request_q.size() >= n / 2) begin
        settle_next = 1'b1;
        settled = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        add_charge(pick_current());
      end else if (pick < 30) begin
        add_poll($urandom_range(0, 1023), 1'($urandom), 1'($urandom));
      end else begin
        k = $urandom_range(0, 2);
        if (pick < 40) begin
          target = $urandom_range(1, TEMP_MAX_C - 1);
        end else begin
          target = $urandom_range(0, 1) ? int'(mdl_trigger[k]) : int'(mdl_release[k]);
          target = target + int'($urandom_range(0, 4)) - 2;
        end
        if (target < 1) target = 1;
        if (target > TEMP_MAX_C - 1) target = TEMP_MAX_C - 1;
        run_len = $urandom_range(1, int'(mdl_persist) + 3);
        repeat (run_len) begin
          if ($urandom_range(0, 4) == 0) add_charge(pick_current());
          add_poll(target + int'(KELVIN_OFFSET), 1'b1, 1'b1);
        end
      end
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic program_limits(input logic [3:0] pc, input logic [6:0] t1, t2, t3,
                                input logic [6:0] r1, r2, r3, input logic [47:0] tab);
    write_reg(REG_PERSIST, 48'(pc));
    write_reg(REG_TRIGGER_ONE, 48'(t1));
    write_reg(REG_TRIGGER_TWO, 48'(t2));
    write_reg(REG_TRIGGER_THREE, 48'(t3));
    write_reg(REG_RELEASE_ONE, 48'(r1));
    write_reg(REG_RELEASE_TWO, 48'(r2));
    write_reg(REG_RELEASE_THREE, 48'(r3));
    write_reg(REG_LIMIT_TABLE, tab);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (request_q.size() != 0 || s_tvalid || n_in != n_out);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      n_in <= 0;
      src_wait = 0;
      mdl_persist = PERSIST_RESET;
      mdl_trigger[0] = TRIGGER_ONE_RESET;
      mdl_trigger[1] = TRIGGER_TWO_RESET;
      mdl_trigger[2] = TRIGGER_THR_RESET;
      mdl_release[0] = RELEASE_ONE_RESET;
      mdl_release[1] = RELEASE_TWO_RESET;
      mdl_release[2] = RELEASE_THR_RESET;
      mdl_table = LIMIT_TABLE_RESET;
      mdl_level = '0;
      mdl_rise = '0;
      mdl_fall = '0;
      mdl_limit = '0;
    end else begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        level_expect_q.push_back(thermal_step(bus_req));
        n_in <= n_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     (!request_q[0].settle || (!s_tvalid && n_in == n_out))) begin
          next_req = request_q.pop_front();
          bus_req = next_req.req;
          s_tdata <= {4'b0, bus_req.charge_ma, bus_req.system_on,
                      bus_req.ext_power, bus_req.sensor_kelvin};
          s_tuser <= bus_req.req_type;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) src_idle = !src_idle;
          src_wait = src_idle ? $urandom_range(0, 3) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      n_out <= 0;
      snk_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out <= n_out + 1;
        got = result_t'(m_tdata[34:0]);
        if (level_expect_q.size() == 0) begin
          log_failure($sformatf("unexpected result: level %0d limit %0d granted %0d",
                                got.limit_level, got.limit_ma, got.granted_current));
        end else begin
          want = level_expect_q.pop_front();
          if (got.limit_level !== want.limit_level ||
              got.limit_ma !== want.limit_ma ||
              got.granted_current !== want.granted_current) begin
            log_failure($sformatf(
              "result %0d mismatch: level %0d/%0d limit %0d/%0d granted %0d/%0d (exp/got)",
              n_out, want.limit_level, got.limit_level, want.limit_ma,
              got.limit_ma, want.granted_current, got.granted_current));
          end
        end
        if ($urandom_range(0, 39) == 0) snk_idle = !snk_idle;
        snk_wait = snk_idle ? $urandom_range(0, 3) : 0;
      end
      if (snk_wait > 0) begin
        snk_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          ph;
    logic [3:0]  pc;
    logic [6:0]  t1, t2, t3, r1, r2, r3;
    logic [47:0] tab;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_charge(16'hFFFF);
    add_charge(16'h0000);
    add_poll(300, 1'b0, 1'b1);
    add_poll(300, 1'b1, 1'b0);
    add_poll(273, 1'b1, 1'b1);
    add_poll(393, 1'b1, 1'b1);
    add_poll(0, 1'b1, 1'b1);
    add_poll(1023, 1'b1, 1'b1);
    add_charge(16'hFFFF);
    add_charge(16'd1234);
    repeat (5) add_poll(392, 1'b1, 1'b1);
    add_charge(16'hFFFF);
    add_poll(274, 1'b1, 1'b1);
    add_poll(1023, 1'b1, 1'b1);
    add_charge(16'h0000);
    add_charge(16'd2300);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      pc = 4'($urandom_range(1, 7));
      t1 = 7'($urandom_range(20, 60));
      t2 = t1 + 7'($urandom_range(0, 20));
      t3 = t2 + 7'($urandom_range(0, 20));
      r1 = (t1 > 7'd8) ? t1 - 7'($urandom_range(0, 8)) : t1;
      r2 = (t2 > 7'd8) ? t2 - 7'($urandom_range(0, 8)) : t2;
      r3 = (t3 > 7'd8) ? t3 - 7'($urandom_range(0, 8)) : t3;
      tab = {16'($urandom), 16'($urandom), 16'($urandom)};
      case (ph)
        0: program_limits(4'd15, 7'd1, 7'd2, 7'd3, 7'd127, 7'd127, 7'd127, {48{1'b1}});
        1: program_limits(4'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 48'd0);
        2: program_limits(4'd0, 7'd60, 7'd70, 7'd80, 7'd50, 7'd60, 7'd70, tab);
        6: program_limits(4'd15, t1, t2, t3, r1, r2, r3, tab);
        7: program_limits(PERSIST_RESET, TRIGGER_ONE_RESET, TRIGGER_TWO_RESET,
                          TRIGGER_THR_RESET, RELEASE_ONE_RESET, RELEASE_TWO_RESET,
                          RELEASE_THR_RESET, LIMIT_TABLE_RESET);
        default: program_limits(pc, t1, t2, t3, r1, r2, r3, tab);
      endcase
      fill_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && level_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/tccl_pkg.sv
rtl/core/tccl_core.sv
rtl/core/thermal_charge_current_limiter_top.sv
tb/sv/tb_thermal_charge_current_limiter_top.sv
